// ===== rtl/bfic_pkg.sv =====
`default_nettype none

package bfic_pkg;

  localparam int PROG_DEPTH = 4096;
  localparam int TAPE_DEPTH = 4096;

  localparam int PA_W = $clog2(PROG_DEPTH);  // program address
  localparam int PC_W = PA_W + 1;            // program counter / length, reaches PROG_DEPTH
  localparam int TA_W = $clog2(TAPE_DEPTH);  // tape address / data pointer

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_RESTART = 2'd1,
    OP_EXEC    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  localparam logic [7:0] CH_GT    = 8'h3E;  // >
  localparam logic [7:0] CH_LT    = 8'h3C;  // <
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // +
  localparam logic [7:0] CH_MINUS = 8'h2D;  // -
  localparam logic [7:0] CH_DOT   = 8'h2E;  // .
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ,
  localparam logic [7:0] CH_LB    = 8'h5B;  // [
  localparam logic [7:0] CH_RB    = 8'h5D;  // ]

endpackage

`default_nettype wire

// ===== rtl/bfic_ram.sv =====
`default_nettype none

module bfic_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/brainfuck_instruction_core.sv =====
`default_nettype none

// Brainfuck instruction core.
// Input channel: an item (in_op, in_prog_char, in_in_byte) is taken at a rising edge
// with start high and busy low. in_op selects append program byte, restart, execute
// one instruction, or clear program.
// Result channel: every item gives exactly one result, shown for one cycle with
// out_strobe high. The receiver cannot stall; the result must be taken that cycle.
// busy drops again in the cycle the result is shown, so the next item may follow.
// Steps from accept to result:
//   append, clear program, execute while halted or at program end: result in the next cycle
//   execute of a plain instruction: program read, then tape read-modify-write in S_EXEC
//   execute of a bracket that jumps: as above, then an S_FSCAN/S_BSCAN program walk
//   restart: result at the end of the tape clearing pass (one cell a cycle)
// Program and tape each sit in a single-port-write, one-read RAM with a registered
// read; the program counter, data pointer and flags are registers.
// Reset: a tape clearing pass over all TAPE_DEPTH cells runs with busy high and gives
// no result. Program length, counter, pointer and flags start at zero.

module brainfuck_instruction_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                in_op,
  input  wire logic [7:0]                in_prog_char,
  input  wire logic [7:0]                in_in_byte,
  output logic                           out_strobe,
  output logic                           out_valid,
  output logic [7:0]                     out_byte,
  output logic                           out_halted,
  output logic                           out_bracket_error,
  output logic                           out_prog_full,
  output logic [bfic_pkg::PC_W-1:0]      out_pc_now,
  output logic [bfic_pkg::TA_W-1:0]      out_ptr_now
);

  import bfic_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FSCAN,
    S_BSCAN
  } state_t;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] len_r, len_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [TA_W-1:0] ptr_r, ptr_nxt;
  logic            halt_r, halt_nxt;
  logic            err_r, err_nxt;
  logic [TA_W-1:0] clr_r, clr_nxt;
  logic            pend_r, pend_nxt;
  logic            strobe_r, strobe_nxt;
  logic            ov_r, ov_nxt;
  logic [7:0]      ob_r, ob_nxt;
  logic            full_r, full_nxt;

  logic [PC_W-1:0] scan_p_r, scan_p_nxt;
  logic [PC_W-1:0] depth_r, depth_nxt;
  logic [7:0]      inbyte_r;

  logic            prog_we;
  logic [PA_W-1:0] prog_raddr;
  logic [7:0]      prog_rdata;
  logic            tape_we;
  logic [TA_W-1:0] tape_waddr;
  logic [7:0]      tape_wdata;
  logic [7:0]      tape_rdata;

  logic [PC_W-1:0] pc_inc;
  logic [PC_W-1:0] scan_nx;
  logic [PC_W-1:0] scan_pv;
  logic [PC_W-1:0] depth_adj;
  logic [PC_W-1:0] new_pc;
  logic            done_ok;
  logic            done_err;
  logic            accept;

  assign accept  = start && (state_r == S_IDLE);
  assign pc_inc  = pc_r + PC_W'(1);
  assign scan_nx = scan_p_r + PC_W'(1);
  assign scan_pv = scan_p_r - PC_W'(1);

  bfic_ram #(.DEPTH(PROG_DEPTH), .WIDTH(8)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (len_r[PA_W-1:0]),
    .wdata (in_prog_char),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  bfic_ram #(.DEPTH(TAPE_DEPTH), .WIDTH(8)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (ptr_r),
    .rdata (tape_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    pc_nxt     = pc_r;
    ptr_nxt    = ptr_r;
    halt_nxt   = halt_r;
    err_nxt    = err_r;
    clr_nxt    = clr_r;
    pend_nxt   = pend_r;
    strobe_nxt = 1'b0;
    ov_nxt     = 1'b0;
    ob_nxt     = 8'd0;
    full_nxt   = 1'b0;
    scan_p_nxt = scan_p_r;
    depth_nxt  = depth_r;
    prog_we    = 1'b0;
    prog_raddr = pc_r[PA_W-1:0];
    tape_we    = 1'b0;
    tape_waddr = ptr_r;
    tape_wdata = 8'd0;
    depth_adj  = depth_r;
    new_pc     = pc_inc;
    done_ok    = 1'b0;
    done_err   = 1'b0;

    case (state_r)
      S_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_r;
        clr_nxt    = clr_r + TA_W'(1);
        if (clr_r == TA_W'(TAPE_DEPTH - 1)) begin
          state_nxt  = S_IDLE;
          strobe_nxt = pend_r;
          pend_nxt   = 1'b0;
        end
      end

      S_IDLE: begin
        if (start) begin
          case (op_t'(in_op))
            OP_APPEND: begin
              strobe_nxt = 1'b1;
              if (len_r < PC_W'(PROG_DEPTH)) begin
                prog_we = 1'b1;
                len_nxt = len_r + PC_W'(1);
              end else begin
                full_nxt = 1'b1;
              end
            end
            OP_RESTART: begin
              pc_nxt    = '0;
              ptr_nxt   = '0;
              halt_nxt  = 1'b0;
              err_nxt   = 1'b0;
              clr_nxt   = '0;
              pend_nxt  = 1'b1;
              state_nxt = S_CLEAR;
            end
            OP_EXEC: begin
              if (halt_r) begin
                strobe_nxt = 1'b1;
              end else if (pc_r >= len_r) begin
                halt_nxt   = 1'b1;
                strobe_nxt = 1'b1;
              end else begin
                // program byte and tape cell come back next cycle
                state_nxt = S_EXEC;
              end
            end
            OP_CLEAR: begin
              len_nxt    = '0;
              pc_nxt     = '0;
              halt_nxt   = 1'b0;
              err_nxt    = 1'b0;
              strobe_nxt = 1'b1;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      S_EXEC: begin
        done_ok = 1'b1;
        case (prog_rdata)
          CH_GT:    ptr_nxt = ptr_r + TA_W'(1);
          CH_LT:    ptr_nxt = ptr_r - TA_W'(1);
          CH_PLUS: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 8'd1;
          end
          CH_MINUS: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - 8'd1;
          end
          CH_DOT: begin
            ov_nxt = 1'b1;
            ob_nxt = tape_rdata;
          end
          CH_COMMA: begin
            tape_we    = 1'b1;
            tape_wdata = inbyte_r;
          end
          CH_LB: begin
            if (tape_rdata == 8'd0) begin
              done_ok = 1'b0;
              if (pc_inc >= len_r) begin
                done_err = 1'b1;
              end else begin
                prog_raddr = pc_inc[PA_W-1:0];
                scan_p_nxt = pc_inc;
                depth_nxt  = PC_W'(1);
                state_nxt  = S_FSCAN;
              end
            end
          end
          CH_RB: begin
            if (tape_rdata != 8'd0) begin
              done_ok = 1'b0;
              if (pc_r == '0) begin
                done_err = 1'b1;
              end else begin
                prog_raddr = pc_r[PA_W-1:0] - PA_W'(1);
                scan_p_nxt = pc_r - PC_W'(1);
                depth_nxt  = PC_W'(1);
                state_nxt  = S_BSCAN;
              end
            end
          end
          default: ;
        endcase
      end

      S_FSCAN: begin
        // stream one program byte a cycle; the read of the next byte is in flight
        if (prog_rdata == CH_LB) begin
          depth_adj = depth_r + PC_W'(1);
        end else if (prog_rdata == CH_RB) begin
          depth_adj = depth_r - PC_W'(1);
        end
        if (depth_adj == '0) begin
          done_ok = 1'b1;
          new_pc  = scan_nx;
        end else if (scan_nx >= len_r) begin
          done_err = 1'b1;
        end else begin
          prog_raddr = scan_nx[PA_W-1:0];
          scan_p_nxt = scan_nx;
          depth_nxt  = depth_adj;
        end
      end

      S_BSCAN: begin
        if (prog_rdata == CH_RB) begin
          depth_adj = depth_r + PC_W'(1);
        end else if (prog_rdata == CH_LB) begin
          depth_adj = depth_r - PC_W'(1);
        end
        if (depth_adj == '0) begin
          done_ok = 1'b1;
          new_pc  = scan_nx;
        end else if (scan_p_r == '0) begin
          done_err = 1'b1;
        end else begin
          prog_raddr = scan_pv[PA_W-1:0];
          scan_p_nxt = scan_pv;
          depth_nxt  = depth_adj;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done_ok) begin
      pc_nxt     = new_pc;
      halt_nxt   = (new_pc >= len_r);
      strobe_nxt = 1'b1;
      state_nxt  = S_IDLE;
    end
    if (done_err) begin
      // unmatched bracket: hold pc on the bracket
      halt_nxt   = 1'b1;
      err_nxt    = 1'b1;
      strobe_nxt = 1'b1;
      state_nxt  = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      len_r    <= '0;
      pc_r     <= '0;
      ptr_r    <= '0;
      halt_r   <= 1'b0;
      err_r    <= 1'b0;
      clr_r    <= '0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
      ov_r     <= 1'b0;
      ob_r     <= 8'd0;
      full_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      pc_r     <= pc_nxt;
      ptr_r    <= ptr_nxt;
      halt_r   <= halt_nxt;
      err_r    <= err_nxt;
      clr_r    <= clr_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
      ov_r     <= ov_nxt;
      ob_r     <= ob_nxt;
      full_r   <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_p_r <= scan_p_nxt;
    depth_r  <= depth_nxt;
    if (accept) begin
      inbyte_r <= in_in_byte;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = strobe_r;
  assign out_valid         = ov_r;
  assign out_byte          = ob_r;
  assign out_halted        = halt_r;
  assign out_bracket_error = err_r;
  assign out_prog_full     = full_r;
  assign out_pc_now        = pc_r;
  assign out_ptr_now       = ptr_r;

`ifndef SYNTHESIS
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> halt_r)
    else $error("bracket error without halt");

  a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= len_r)
    else $error("program counter past program length");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_APPEND || in_op == OP_CLEAR)) |=> strobe_r)
    else $error("append or clear gave no result in the next cycle");

  a_tape_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    tape_we |-> (state_r == S_EXEC || state_r == S_CLEAR))
    else $error("tape written outside execute or clearing pass");
`endif

endmodule

`default_nettype wire
